// ----- rtl/skm_pkg.sv -----
// Shared types for the sorted record k-way merge: controller states, the
// command and status bundles between controller and datapath, and the key helpers.
// No dependencies.
package skm_pkg;

   localparam int StreamCap = 16;   // stream_index is 4 bits wide
   localparam int IdxW      = 4;
   localparam int CfgW      = 5;
   localparam int KeyW      = 65;   // {ref_id, position, strand}

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_EVAL,
      ST_REDUCE,
      ST_EMIT,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic capture;     // input transfer this cycle: update head table
      logic load_tree;   // load candidates from the head table
      logic reduce;      // one level of the compare tree
      logic emit_rec;    // load the winning head into the output register
      logic emit_done;   // load the done result into the output register
   } cmd_type;

   typedef struct packed {
      logic all_ended;
      logic all_ready;
      logic rsp_free;
   } stat_type;

   typedef struct packed {
      logic            valid;
      logic [KeyW-1:0] key;
      logic [IdxW-1:0] idx;
   } cand_type;

   // sign bits flipped so an unsigned compare orders signed fields
   function automatic logic [KeyW-1:0] make_key(logic [31:0] r, logic [31:0] p, logic s);
      return {~r[31], r[30:0], ~p[31], p[30:0], s};
   endfunction

   // left operand holds the lower stream indices, so ties keep it
   function automatic cand_type pick(cand_type a, cand_type b);
      if (!b.valid) begin
         return a;
      end
      if (!a.valid) begin
         return b;
      end
      if (b.key < a.key) begin
         return b;
      end
      return a;
   endfunction

endpackage

// ----- rtl/sorted_record_kway_merge_top.sv -----
// Sorted record k-way merge, top level: joins the controller and the datapath.
// Depends on skm_pkg, skm_ctrl and skm_datapath.
//
// Merges up to min(MAX_STREAMS, 16) sorted record streams by the key
// (ref_id, position, strand), ref_id and position compared as signed values.
// Each input transfer carries the next record of one stream or its end mark.
// Once every unfinished stream holds a head, the smallest head is sent out
// with its source stream, which is the one to refill; ties go to the lowest
// stream index. When all streams in use have ended, a done result (all record
// fields zero) is sent for that transfer and for every later one. The stream
// count (csr_data, reset value 2) is clamped to 1..min(MAX_STREAMS, 16). The user
// must see that it is written only while the block is idle; the block itself
// does not enforce this. csr_ready is always high. An input transfer is captured
// while idle and evaluated; it yields no result, a done result or a record result
// from the pairwise compare tree, which resolves one level per cycle. A result is
// emitted once the output register is free. One item is in work at a time; a
// result waiting in the output register does not stop the next input being taken.
module sorted_record_kway_merge_top import skm_pkg::*; #(
   parameter int MAX_STREAMS = 16
) (
   input  logic               clock,
   input  logic               reset,
   // configuration write channel
   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic [CfgW-1:0]    csr_data,
   // input channel
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [IdxW-1:0]    req_stream_index,
   input  logic               req_end_of_stream,
   input  logic signed [31:0] req_ref_id,
   input  logic signed [31:0] req_position,
   input  logic               req_strand,
   input  logic [31:0]        req_record_tag,
   // result channel
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic signed [31:0] rsp_out_ref_id,
   output logic signed [31:0] rsp_out_position,
   output logic               rsp_out_strand,
   output logic [31:0]        rsp_out_tag,
   output logic [IdxW-1:0]    rsp_source_stream,
   output logic               rsp_all_done
);

   localparam int DEPTH  = (MAX_STREAMS < StreamCap) ? MAX_STREAMS : StreamCap;
   localparam int LEVELS = $clog2(DEPTH);

   cmd_type  cmd;
   stat_type stat;

   // register writes are always taken
   assign csr_ready = 1'b1;

   skm_ctrl #(
      .LEVELS (LEVELS)
   ) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .stat      (stat),
      .cmd       (cmd)
   );

   skm_datapath #(
      .MAX_STREAMS (MAX_STREAMS)
   ) u_datapath (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .stat              (stat),
      .csr_valid         (csr_valid),
      .csr_data          (csr_data),
      .req_stream_index  (req_stream_index),
      .req_end_of_stream (req_end_of_stream),
      .req_ref_id        (req_ref_id),
      .req_position      (req_position),
      .req_strand        (req_strand),
      .req_record_tag    (req_record_tag),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_out_ref_id    (rsp_out_ref_id),
      .rsp_out_position  (rsp_out_position),
      .rsp_out_strand    (rsp_out_strand),
      .rsp_out_tag       (rsp_out_tag),
      .rsp_source_stream (rsp_source_stream),
      .rsp_all_done      (rsp_all_done)
   );

endmodule

// ----- rtl/skm_ctrl.sv -----
// Controller of the k-way merge: sequences capture, evaluation, tree reduction
// and result emission. Depends on skm_pkg.
module skm_ctrl import skm_pkg::*; #(
   parameter int LEVELS = 4
) (
   input  logic     clock,
   input  logic     reset,
   input  logic     req_valid,
   output logic     req_stall,
   input  stat_type stat,
   output cmd_type  cmd
);

   localparam int LW = $clog2(LEVELS + 1);

   state_type       state_ff, state_in;
   logic [LW-1:0]   lvl_ff, lvl_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         lvl_ff   <= '0;
      end else begin
         state_ff <= state_in;
         lvl_ff   <= lvl_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      lvl_in    = lvl_ff;
      cmd       = '0;
      req_stall = 1'b1;
      case (state_ff)
         ST_IDLE: begin
            req_stall   = 1'b0;
            cmd.capture = req_valid;
            if (req_valid) begin
               state_in = ST_EVAL;
            end
         end
         ST_EVAL: begin
            if (stat.all_ended) begin
               state_in = ST_DONE;
            end else if (stat.all_ready) begin
               cmd.load_tree = 1'b1;
               lvl_in        = '0;
               state_in      = ST_REDUCE;
            end else begin
               state_in = ST_IDLE;
            end
         end
         ST_REDUCE: begin
            cmd.reduce = 1'b1;
            if (lvl_ff == LW'(LEVELS - 1)) begin
               state_in = ST_EMIT;
            end else begin
               lvl_in = lvl_ff + 1'b1;
            end
         end
         ST_EMIT: begin
            if (stat.rsp_free) begin
               cmd.emit_rec = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         ST_DONE: begin
            if (stat.rsp_free) begin
               cmd.emit_done = 1'b1;
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

// ----- rtl/skm_datapath.sv -----
// Datapath of the k-way merge: stream count register, head table, compare
// tree and output register. Depends on skm_pkg.
module skm_datapath import skm_pkg::*; #(
   parameter int MAX_STREAMS = 16
) (
   input  logic               clock,
   input  logic               reset,
   input  cmd_type            cmd,
   output stat_type           stat,
   input  logic               csr_valid,
   input  logic [CfgW-1:0]    csr_data,
   input  logic [IdxW-1:0]    req_stream_index,
   input  logic               req_end_of_stream,
   input  logic signed [31:0] req_ref_id,
   input  logic signed [31:0] req_position,
   input  logic               req_strand,
   input  logic [31:0]        req_record_tag,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic signed [31:0] rsp_out_ref_id,
   output logic signed [31:0] rsp_out_position,
   output logic               rsp_out_strand,
   output logic [31:0]        rsp_out_tag,
   output logic [IdxW-1:0]    rsp_source_stream,
   output logic               rsp_all_done
);

   localparam int DEPTH = (MAX_STREAMS < StreamCap) ? MAX_STREAMS : StreamCap;
   localparam int SW    = $clog2(DEPTH);
   localparam int P     = 1 << SW;

   logic [CfgW-1:0]  cfg_ff;
   logic [CfgW-1:0]  n_eff;

   logic [31:0]      head_ref_ff    [DEPTH];
   logic [31:0]      head_pos_ff    [DEPTH];
   logic             head_strand_ff [DEPTH];
   logic [31:0]      head_tag_ff    [DEPTH];
   logic [DEPTH-1:0] present_ff;
   logic [DEPTH-1:0] finished_ff;

   cand_type         cand_ff [P];
   cand_type         cand_in [P];

   logic [SW-1:0]    widx;
   logic             in_range;
   logic [SW-1:0]    win;

   logic               rsp_valid_ff;
   logic signed [31:0] rsp_ref_ff, rsp_pos_ff;
   logic               rsp_strand_ff, rsp_done_ff;
   logic [31:0]        rsp_tag_ff;
   logic [IdxW-1:0]    rsp_src_ff;

   // stream count register, clamped to [1, DEPTH] on use
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= CfgW'(2);
      end else if (csr_valid) begin
         cfg_ff <= csr_data;
      end
   end

   always_comb begin
      if (cfg_ff == '0) begin
         n_eff = CfgW'(1);
      end else if (cfg_ff > CfgW'(DEPTH)) begin
         n_eff = CfgW'(DEPTH);
      end else begin
         n_eff = cfg_ff;
      end
   end

   assign widx     = req_stream_index[SW-1:0];
   assign in_range = ({1'b0, req_stream_index} < n_eff);
   assign win      = cand_ff[0].idx[SW-1:0];

   // head payload, no reset
   always_ff @(posedge clock) begin
      if (cmd.capture && in_range && !finished_ff[widx] && !req_end_of_stream
          && !present_ff[widx]) begin
         head_ref_ff[widx]    <= req_ref_id;
         head_pos_ff[widx]    <= req_position;
         head_strand_ff[widx] <= req_strand;
         head_tag_ff[widx]    <= req_record_tag;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         present_ff  <= '0;
         finished_ff <= '0;
      end else if (cmd.capture) begin
         if (in_range && !finished_ff[widx]) begin
            if (req_end_of_stream) begin
               finished_ff[widx] <= 1'b1;
               present_ff[widx]  <= 1'b0;
            end else begin
               present_ff[widx] <= 1'b1;
            end
         end
      end else if (cmd.emit_rec) begin
         present_ff[win] <= 1'b0;
      end
   end

   // stream status over the active range
   always_comb begin
      stat.all_ended = 1'b1;
      stat.all_ready = 1'b1;
      for (int i = 0; i < DEPTH; i++) begin
         if (CfgW'(i) < n_eff && !finished_ff[i]) begin
            stat.all_ended = 1'b0;
            if (!present_ff[i]) begin
               stat.all_ready = 1'b0;
            end
         end
      end
      stat.rsp_free = !rsp_valid_ff || !rsp_stall;
   end

   // compare tree: each reduce halves the live candidates in place
   always_comb begin
      for (int i = 0; i < P; i++) begin
         cand_in[i] = cand_ff[i];
      end
      if (cmd.load_tree) begin
         for (int i = 0; i < P; i++) begin
            cand_in[i] = '0;
            if (i < DEPTH) begin
               cand_in[i].valid = (CfgW'(i) < n_eff) && !finished_ff[i] && present_ff[i];
               cand_in[i].key   = make_key(head_ref_ff[i], head_pos_ff[i],
                                           head_strand_ff[i]);
               cand_in[i].idx   = IdxW'(i);
            end
         end
      end else if (cmd.reduce) begin
         for (int i = 0; i < P / 2; i++) begin
            cand_in[i] = pick(cand_ff[2*i], cand_ff[2*i+1]);
         end
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < P; i++) begin
         cand_ff[i] <= cand_in[i];
      end
   end

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.emit_rec || cmd.emit_done) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.emit_rec) begin
         rsp_ref_ff    <= head_ref_ff[win];
         rsp_pos_ff    <= head_pos_ff[win];
         rsp_strand_ff <= head_strand_ff[win];
         rsp_tag_ff    <= head_tag_ff[win];
         rsp_src_ff    <= cand_ff[0].idx;
         rsp_done_ff   <= 1'b0;
      end else if (cmd.emit_done) begin
         rsp_ref_ff    <= '0;
         rsp_pos_ff    <= '0;
         rsp_strand_ff <= 1'b0;
         rsp_tag_ff    <= '0;
         rsp_src_ff    <= '0;
         rsp_done_ff   <= 1'b1;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_out_ref_id    = rsp_ref_ff;
   assign rsp_out_position  = rsp_pos_ff;
   assign rsp_out_strand    = rsp_strand_ff;
   assign rsp_out_tag       = rsp_tag_ff;
   assign rsp_source_stream = rsp_src_ff;
   assign rsp_all_done      = rsp_done_ff;

endmodule

// ----- dv/sorted_record_kway_merge_top_tb.sv -----
// Testbench for sorted_record_kway_merge_top: directed and random merges with
// a built-in predictor of the merge, checked transfer by transfer.
// Depends on skm_pkg and the RTL of the merge block only.
module sorted_record_kway_merge_top_tb import skm_pkg::*;;

   localparam int MaxStreams    = 16;
   localparam int HalfPeriod    = 6;
   localparam int DrainCycles   = 12;          // covers the record path
   localparam int TimeoutCycles = 400000;
   localparam logic EndMark     = 1'b1;
   localparam logic DataRec     = 1'b0;
   localparam logic signed [31:0] CoordTop  = 32'sh7fffffff;
   localparam logic signed [31:0] CoordNone = -32'sd1;
   localparam longint CoordMax  = 64'sd2147483647;

   typedef struct packed {
      logic [IdxW-1:0]    idx;
      logic               eos;
      logic signed [31:0] ref_id;
      logic signed [31:0] pos;
      logic               strand;
      logic [31:0]        tag;
   } merge_in_type;

   typedef struct packed {
      logic signed [31:0] ref_id;
      logic signed [31:0] pos;
      logic               strand;
      logic [31:0]        tag;
      logic [IdxW-1:0]    src;
      logic               done;
   } merge_out_type;

   typedef enum {STALL_NONE, STALL_LIGHT, STALL_HEAVY, STALL_PERIODIC} stall_mode_type;

   // DUT ports, inputs known from time zero
   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               csr_valid = 1'b0;
   logic               csr_ready;
   logic [CfgW-1:0]    csr_data = '0;
   logic               req_valid = 1'b0;
   logic               req_stall;
   logic [IdxW-1:0]    req_stream_index = '0;
   logic               req_end_of_stream = 1'b0;
   logic signed [31:0] req_ref_id = '0;
   logic signed [31:0] req_position = '0;
   logic               req_strand = 1'b0;
   logic [31:0]        req_record_tag = '0;
   logic               rsp_valid;
   logic               rsp_stall = 1'b0;
   logic signed [31:0] rsp_out_ref_id;
   logic signed [31:0] rsp_out_position;
   logic               rsp_out_strand;
   logic [31:0]        rsp_out_tag;
   logic [IdxW-1:0]    rsp_source_stream;
   logic               rsp_all_done;

   // predictor state: register plus per-stream head table
   logic [CfgW-1:0] stream_count = 5'd2;
   merge_in_type    head_rec[StreamCap];
   logic            head_held[StreamCap] = '{default: 1'b0};
   logic            stream_closed[StreamCap] = '{default: 1'b0};
   merge_out_type   merge_out_q[$];

   // per-stream sorted sources for the random merges
   int              records_left[StreamCap];
   longint          last_ref[StreamCap];
   longint          last_pos[StreamCap];
   logic            last_strand[StreamCap];

   // pacing and bookkeeping
   int              burst_left = 0;
   bit              steady_feed = 1'b0;
   int              rsp_hold_req = 0;
   int              mismatch_count = 0;
   int              items_sent = 0;
   int              offpattern_sent = 0;
   int              records_seen = 0;
   int              done_seen = 0;

   sorted_record_kway_merge_top #(.MAX_STREAMS(MaxStreams)) dut (
      .clock             (clock),
      .reset             (reset),
      .csr_valid         (csr_valid),
      .csr_ready         (csr_ready),
      .csr_data          (csr_data),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_stream_index  (req_stream_index),
      .req_end_of_stream (req_end_of_stream),
      .req_ref_id        (req_ref_id),
      .req_position      (req_position),
      .req_strand        (req_strand),
      .req_record_tag    (req_record_tag),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_out_ref_id    (rsp_out_ref_id),
      .rsp_out_position  (rsp_out_position),
      .rsp_out_strand    (rsp_out_strand),
      .rsp_out_tag       (rsp_out_tag),
      .rsp_source_stream (rsp_source_stream),
      .rsp_all_done      (rsp_all_done)
   );

   always begin
      #HalfPeriod clock = 1'b1;
      #HalfPeriod clock = 1'b0;
   end

   // ---------------------------------------------------------------------
   // Merge predictor
   // ---------------------------------------------------------------------

   // register value clamped to 1..min(MaxStreams, StreamCap)
   function automatic int active_streams();
      int n;
      n = stream_count;
      if (n < 1) n = 1;
      if (n > MaxStreams) n = MaxStreams;
      if (n > StreamCap) n = StreamCap;
      return n;
   endfunction

   // key order: ref_id, then position (both signed), then strand
   function automatic bit key_before(int a, int b);
      if (head_rec[a].ref_id != head_rec[b].ref_id)
         return $signed(head_rec[a].ref_id) < $signed(head_rec[b].ref_id);
      if (head_rec[a].pos != head_rec[b].pos)
         return $signed(head_rec[a].pos) < $signed(head_rec[b].pos);
      return head_rec[a].strand < head_rec[b].strand;
   endfunction

   // applies one accepted input; returns 1 with the merged result if one is due
   function automatic bit predict_merge_output(input merge_in_type item,
                                               output merge_out_type res);
      int n;
      int best;
      bit all_ended;
      bit all_ready;
      bit have;
      n = active_streams();
      best = 0;
      all_ended = 1'b1;
      all_ready = 1'b1;
      have = 1'b0;
      res = '0;
      // out-of-range index or closed stream: no state change
      if (item.idx < n && !stream_closed[item.idx]) begin
         if (item.eos) begin
            stream_closed[item.idx] = 1'b1;
            head_held[item.idx] = 1'b0;   // held head is dropped
         end else if (!head_held[item.idx]) begin
            head_rec[item.idx] = item;
            head_held[item.idx] = 1'b1;
         end
      end
      for (int i = 0; i < n; i++) begin
         if (!stream_closed[i]) begin
            all_ended = 1'b0;
            if (!head_held[i]) all_ready = 1'b0;
         end
      end
      if (all_ended) begin
         res.done = 1'b1;
         return 1'b1;
      end
      if (!all_ready) return 1'b0;
      // strict less-than keeps the lowest index on ties
      for (int i = 0; i < n; i++) begin
         if (stream_closed[i] || !head_held[i]) continue;
         if (!have || key_before(i, best)) begin
            best = i;
            have = 1'b1;
         end
      end
      if (!have) return 1'b0;
      res.ref_id = head_rec[best].ref_id;
      res.pos    = head_rec[best].pos;
      res.strand = head_rec[best].strand;
      res.tag    = head_rec[best].tag;
      res.src    = best[IdxW-1:0];
      head_held[best] = 1'b0;
      return 1'b1;
   endfunction

   // ---------------------------------------------------------------------
   // Input side
   // ---------------------------------------------------------------------

   // one input transfer; bursts with random gaps unless steady_feed is set
   task automatic send_item(logic [IdxW-1:0] idx, logic eos, logic signed [31:0] ref_id,
                            logic signed [31:0] pos, logic strand, logic [31:0] tag);
      merge_in_type  item;
      merge_out_type res;
      int            gap;
      item = '{idx: idx, eos: eos, ref_id: ref_id, pos: pos, strand: strand, tag: tag};
      if (!steady_feed) begin
         if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap != 0) begin
               @(negedge clock) req_valid <= 1'b0;
               repeat (gap - 1) @(negedge clock);
            end
         end
         burst_left--;
      end
      @(negedge clock);
      req_valid         <= 1'b1;
      req_stream_index  <= idx;
      req_end_of_stream <= eos;
      req_ref_id        <= ref_id;
      req_position      <= pos;
      req_strand        <= strand;
      req_record_tag    <= tag;
      do @(posedge clock); while (req_stall !== 1'b0);
      items_sent++;
      if (predict_merge_output(item, res)) merge_out_q.push_back(res);
   endtask

   // drop valid, wait for every expected result, then let the block settle
   task automatic drain_merge();
      @(negedge clock) req_valid <= 1'b0;
      while (merge_out_q.size() != 0) @(posedge clock);
      repeat (DrainCycles) @(posedge clock);
   endtask

   // register write; only called with the block idle
   task automatic write_stream_count(int value);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_data  <= value[CfgW-1:0];
      do @(posedge clock); while (csr_ready !== 1'b1);
      stream_count = value[CfgW-1:0];
      @(negedge clock) csr_valid <= 1'b0;
   endtask

   function automatic logic signed [31:0] random_coordinate();
      case ($urandom_range(0, 4))
         0:       return CoordNone;
         1:       return 32'sd0;
         2:       return CoordTop;
         3:       return $urandom_range(0, 20);
         default: return $urandom_range(0, 32'h7fffffff);
      endcase
   endfunction

   // anything goes: out-of-range index, record for a held or closed stream,
   // out-of-order key, an occasional early end mark
   task automatic send_offpattern_item();
      offpattern_sent++;
      send_item(IdxW'($urandom_range(0, StreamCap - 1)), ($urandom_range(0, 19) == 0),
                random_coordinate(), random_coordinate(), 1'($urandom_range(0, 1)),
                $urandom);
   endtask

   // next record of stream s in key order, or its end mark once it runs dry
   task automatic send_next_in_order(int s);
      longint r;
      longint p;
      logic   st;
      int     step;
      if (records_left[s] == 0) begin
         send_item(IdxW'(s), EndMark, random_coordinate(), random_coordinate(),
                   1'($urandom_range(0, 1)), $urandom);
         return;
      end
      r = last_ref[s];
      p = last_pos[s];
      st = 1'($urandom_range(0, 1));
      case ($urandom_range(0, 19))
         0: begin
            r += $urandom_range(1, 32'h4000_0000);
            p = $urandom_range(0, 1000);
         end
         1, 2: begin
            r += 1;
            p = $urandom_range(0, 40);
         end
         3: p += $urandom_range(1, 32'h4000_0000);
         default: begin
            // small steps keep keys colliding across streams
            step = $urandom_range(0, 3);
            p += step;
            if (step == 0) st = last_strand[s] | st;
         end
      endcase
      if (r > CoordMax) r = CoordMax;
      if (p > CoordMax) p = CoordMax;
      // saturation at the top must not break the order
      if (r == last_ref[s] && p < last_pos[s]) p = last_pos[s];
      if (r == last_ref[s] && p == last_pos[s]) st = st | last_strand[s];
      last_ref[s] = r;
      last_pos[s] = p;
      last_strand[s] = st;
      records_left[s]--;
      send_item(IdxW'(s), DataRec, r[31:0], p[31:0], st, $urandom);
   endtask

   // a stream in range that is open and waits for a refill
   function automatic bit pick_refill_stream(output int s);
      int cand[$];
      s = 0;
      for (int i = 0; i < active_streams(); i++)
         if (!stream_closed[i] && !head_held[i]) cand.push_back(i);
      if (cand.size() == 0) return 1'b0;
      s = cand[$urandom_range(0, cand.size() - 1)];
      return 1'b1;
   endfunction

   // mostly well-formed refills, about one in seven off-pattern
   task automatic send_merge_item();
      int s;
      if ($urandom_range(0, 99) < 15 || !pick_refill_stream(s))
         send_offpattern_item();
      else
         send_next_in_order(s);
   endtask

   function automatic bit all_streams_closed();
      for (int i = 0; i < StreamCap; i++)
         if (!stream_closed[i]) return 1'b0;
      return 1'b1;
   endfunction

   // budget 0: keep going until every stream has ended
   task automatic run_merge_phase(int count_value, int budget);
      int sent;
      sent = 0;
      write_stream_count(count_value);
      while (budget == 0 ? !all_streams_closed() : sent < budget) begin
         send_merge_item();
         sent++;
      end
      drain_merge();
   endtask

   // ---------------------------------------------------------------------
   // Result side: stall pattern and checker
   // ---------------------------------------------------------------------

   // stall pattern is redrawn at random when its run expires; a hold request from
   // a test overrides it with a steady stall
   stall_mode_type stall_mode = STALL_NONE;
   int             pattern_left = 0;
   int             hold_left = 0;
   int             stall_phase = 0;

   always @(negedge clock) begin
      if (rsp_hold_req != 0) begin
         hold_left = rsp_hold_req;
         rsp_hold_req = 0;
      end
      if (pattern_left == 0) begin
         stall_mode = stall_mode_type'($urandom_range(0, 3));
         pattern_left = $urandom_range(20, 150);
      end
      pattern_left--;
      stall_phase = (stall_phase + 1) % 5;
      if (hold_left != 0) begin
         hold_left--;
         rsp_stall <= 1'b1;
      end else begin
         case (stall_mode)
            STALL_LIGHT:    rsp_stall <= ($urandom_range(0, 3) == 0);
            STALL_HEAVY:    rsp_stall <= ($urandom_range(0, 9) < 7);
            STALL_PERIODIC: rsp_stall <= (stall_phase < 3);
            default:        rsp_stall <= 1'b0;
         endcase
      end
   end

   task automatic check_field(string field, logic [31:0] want, logic [31:0] got);
      if (got !== want) begin
         $error("%s: expected %0h, got %0h", field, want, got);
         mismatch_count++;
      end
   endtask

   always @(posedge clock) begin
      merge_out_type want;
      if (!reset && rsp_valid === 1'b1 && rsp_stall === 1'b0) begin
         if (merge_out_q.size() == 0) begin
            $error("result transfer with nothing expected (src %0d, done %0b)",
                   rsp_source_stream, rsp_all_done);
            mismatch_count++;
         end else begin
            want = merge_out_q.pop_front();
            check_field("out_ref_id", want.ref_id, rsp_out_ref_id);
            check_field("out_position", want.pos, rsp_out_position);
            check_field("out_strand", want.strand, rsp_out_strand);
            check_field("out_tag", want.tag, rsp_out_tag);
            check_field("source_stream", want.src, rsp_source_stream);
            check_field("all_done", want.done, rsp_all_done);
            if (want.done) done_seen++;
            else records_seen++;
         end
      end
   end

   // ---------------------------------------------------------------------
   // Tests
   // ---------------------------------------------------------------------

   // reset count of 2, then 4: key extremes, ties, ignored items, end marks
   task automatic test_directed_merge();
      send_item(15, DataRec, 32'sd3, 32'sd3, 1'b0, 32'h1234_5678);  // index outside count
      send_item(0, DataRec, CoordNone, CoordNone, 1'b1, 32'hffff_ffff);
      send_item(0, DataRec, 32'sd0, 32'sd0, 1'b0, 32'h0000_0bad);    // stream already holds a head
      send_item(1, DataRec, CoordNone, CoordNone, 1'b1, 32'h0);      // tie, stream 0 wins
      send_item(0, DataRec, CoordNone, CoordNone, 1'b1, 32'h1);      // tie again
      send_item(0, DataRec, 32'sd0, 32'sd0, 1'b0, 32'h2);
      send_item(1, DataRec, 32'sd0, 32'sd0, 1'b1, 32'h3);
      send_item(0, DataRec, CoordTop, CoordTop, 1'b1, 32'h8000_0000);
      send_item(1, DataRec, CoordTop, CoordTop, 1'b0, 32'h7fff_ffff); // strand decides
      send_item(1, EndMark, 32'sd0, 32'sd0, 1'b0, 32'h0);
      send_item(1, DataRec, 32'sd1, 32'sd1, 1'b0, 32'h5);            // ended stream
      send_item(0, DataRec, 32'sd5, 32'sd5, 1'b0, 32'h6);
      drain_merge();
      // streams 2 and 3 join with stream 1 already ended
      write_stream_count(4);
      send_item(0, DataRec, 32'sd10, 32'sd10, 1'b0, 32'h10);
      send_item(2, DataRec, 32'sd20, 32'sd0, 1'b0, 32'h20);
      send_item(3, DataRec, 32'sd5, 32'sd0, 1'b0, 32'h30);
      send_item(2, EndMark, CoordNone, CoordTop, 1'b1, 32'hdead_beef); // drops held head
      send_item(3, DataRec, 32'sd30, 32'sd0, 1'b0, 32'h31);
      send_item(0, EndMark, 32'sd0, 32'sd0, 1'b0, 32'h0);
      send_item(3, EndMark, 32'sd0, 32'sd0, 1'b0, 32'h0);            // all ended: done
      send_item(2, DataRec, 32'sd1, 32'sd2, 1'b1, 32'h40);           // done repeats
      drain_merge();
   endtask

   // clamp at both ends of the register; streams 0..3 have ended by now
   task automatic test_count_extremes();
      write_stream_count(0);
      send_item(0, DataRec, 32'sd7, 32'sd7, 1'b0, 32'h50);
      send_item(15, EndMark, CoordTop, CoordTop, 1'b1, 32'hffff_ffff);
      drain_merge();
      write_stream_count(31);
   endtask

   // sorted sources for the untouched streams, merged under several counts;
   // lowering the count mid-merge keeps heads of the streams left out
   task automatic test_random_merge();
      for (int i = 4; i < StreamCap; i++) begin
         records_left[i] = $urandom_range(30, 110);
         last_ref[i] = ($urandom_range(0, 3) == 0) ? -64'sd1
                                                   : longint'($urandom_range(0, 2));
         last_pos[i] = ($urandom_range(0, 1) == 0) ? -64'sd1
                                                   : longint'($urandom_range(0, 20));
         last_strand[i] = 1'b0;
      end
      run_merge_phase(8, 180);
      run_merge_phase(5, 180);
      run_merge_phase($urandom_range(9, 15), 180);
   endtask

   // receiver holds off for a long stretch while the sender keeps offering,
   // so the block fills up and stalls its input
   task automatic test_backpressure();
      write_stream_count(12);
      steady_feed = 1'b1;
      rsp_hold_req = 400;
      repeat (60) send_merge_item();
      steady_feed = 1'b0;
      drain_merge();
   endtask

   // clamped high count: merge until every stream has ended, then done repeats
   task automatic test_merge_to_end();
      run_merge_phase(20, 0);
      repeat (4) send_offpattern_item();
   endtask

   initial begin
      int guard;
      repeat (5) @(posedge clock);
      @(negedge clock) reset <= 1'b0;
      test_directed_merge();
      test_count_extremes();
      test_random_merge();
      test_backpressure();
      test_merge_to_end();
      @(negedge clock) req_valid <= 1'b0;
      for (guard = 0; merge_out_q.size() != 0 && guard < 20000; guard++) @(posedge clock);
      repeat (DrainCycles) @(posedge clock);
      if (merge_out_q.size() != 0) begin
         $error("%0d expected results never arrived", merge_out_q.size());
         mismatch_count += merge_out_q.size();
      end
      $display("Run covered %0d input transfers (%0d off-pattern), %0d merged records, %0d done",
               items_sent, offpattern_sent, records_seen, done_seen);
      $display("Stream counts went from the clamped low end through mid values to the high end");
      if (mismatch_count == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

   // hard stop in case a handshake never completes
   initial begin
      #(TimeoutCycles * 2 * HalfPeriod);
      $display("Mismatches found");
      $finish;
   end

endmodule
